@@ sv/ccsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ccsc_pkg: shared types and constants of the C comment and string checker
// Character codes, report codes, line counter width and channel payloads.
// ----------------------------------------------------------------------------
package ccsc_pkg;

   // line counter width and the width of the reported line field
   localparam int LINE_BITS       = 20;
   localparam int LINE_FIELD_BITS = 20;

   // characters the scanner looks for
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;

   // report codes
   localparam logic [2:0] ERR_STR_EOF   = 3'd0;
   localparam logic [2:0] ERR_STR_EOL   = 3'd1;
   localparam logic [2:0] ERR_CHR_EOF   = 3'd2;
   localparam logic [2:0] ERR_CHR_EOL   = 3'd3;
   localparam logic [2:0] ERR_STRAY_END = 3'd4;
   localparam logic [2:0] ERR_CMT_EOF   = 3'd5;
   localparam logic [2:0] ERR_CMT_START = 3'd6;
   localparam logic [2:0] ERR_NESTED    = 3'd7;

   // input item
   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_file;
   } ccsc_req_type;

   // one report
   typedef struct packed {
      logic [2:0]                 error_code;
      logic [LINE_FIELD_BITS-1:0] line;
      logic                       last_of_run;
   } ccsc_rsp_type;

   // reports caused by one item, handed from scanner to queue
   typedef struct packed {
      logic [1:0]   count;
      ccsc_rsp_type item0;
      ccsc_rsp_type item1;
   } ccsc_push_type;

endpackage

@@ sv/ccsc_scanner.sv @@
// ----------------------------------------------------------------------------
// ccsc_scanner: character scanner state and report generation
// Holds the scan state and line counters; builds up to two reports per item.
// ----------------------------------------------------------------------------
module ccsc_scanner
   import ccsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  ccsc_req_type  req,
   output ccsc_push_type push
);

   typedef enum logic [3:0] {
      S_TEXT, S_STR, S_STR_ESC, S_CHR, S_CHR_ESC, S_MAYBE_STRAY,
      S_MAYBE_OPEN, S_CMT, S_MAYBE_CLOSE, S_MAYBE_NEST, S_LINE_CMT
   } scan_state_type;

   scan_state_type         state_ff, state_in;
   logic [LINE_BITS-1:0]   open_line_ff, open_line_in;
   logic [LINE_BITS-1:0]   cur_line_ff, cur_line_in;

   scan_state_type         text_state;
   logic                   text_open;
   logic                   is_nl;
   logic [LINE_FIELD_BITS-1:0] open_field, cur_field;

   assign is_nl      = (req.ch == CH_NL);
   assign open_field = LINE_FIELD_BITS'(open_line_ff);
   assign cur_field  = LINE_FIELD_BITS'(cur_line_ff);

   // what a character does when seen in text (also for a pushed-back one)
   always_comb begin
      text_state = S_TEXT;
      text_open  = 1'b0;
      case (req.ch)
         CH_DQUOTE: begin text_state = S_STR;         text_open = 1'b1; end
         CH_SQUOTE: begin text_state = S_CHR;         text_open = 1'b1; end
         CH_SLASH:  begin text_state = S_MAYBE_OPEN;  text_open = 1'b1; end
         CH_STAR:   begin text_state = S_MAYBE_STRAY; end
         default:   begin text_state = S_TEXT; end
      endcase
   end

   // next state and reports
   always_comb begin
      state_in     = state_ff;
      open_line_in = open_line_ff;
      cur_line_in  = cur_line_ff;
      push         = '0;
      if (req.end_of_file) begin
         case (state_ff)
            S_STR, S_STR_ESC: begin
               push.count = 2'd1;
               push.item0 = '{ERR_STR_EOF, open_field, 1'b1};
            end
            S_CHR, S_CHR_ESC: begin
               push.count = 2'd1;
               push.item0 = '{ERR_CHR_EOF, open_field, 1'b1};
            end
            S_CMT, S_MAYBE_CLOSE, S_MAYBE_NEST: begin
               push.count = 2'd1;
               push.item0 = '{ERR_CMT_EOF, open_field, 1'b1};
            end
            default: begin end
         endcase
         state_in     = S_TEXT;
         cur_line_in  = LINE_BITS'(1);
         open_line_in = '0;
      end else begin
         case (state_ff)
            S_STR: begin
               if (is_nl) begin
                  push.count = 2'd1;
                  push.item0 = '{ERR_STR_EOL, open_field, 1'b1};
                  state_in   = S_TEXT;
               end else if (req.ch == CH_DQUOTE) begin
                  state_in = S_TEXT;
               end else if (req.ch == CH_BSLASH) begin
                  state_in = S_STR_ESC;
               end
            end
            S_STR_ESC: state_in = S_STR;
            S_CHR: begin
               if (is_nl) begin
                  push.count = 2'd1;
                  push.item0 = '{ERR_CHR_EOL, open_field, 1'b1};
                  state_in   = S_TEXT;
               end else if (req.ch == CH_SQUOTE) begin
                  state_in = S_TEXT;
               end else if (req.ch == CH_BSLASH) begin
                  state_in = S_CHR_ESC;
               end
            end
            S_CHR_ESC: state_in = S_CHR;
            S_MAYBE_STRAY: begin
               if (req.ch == CH_SLASH) begin
                  push.count = 2'd1;
                  push.item0 = '{ERR_STRAY_END, cur_field, 1'b1};
                  state_in   = S_TEXT;
               end else begin
                  // character examined again as text
                  state_in = text_state;
                  if (text_open) open_line_in = cur_line_ff;
               end
            end
            S_MAYBE_OPEN: begin
               if (req.ch == CH_STAR) begin
                  state_in = S_CMT;
               end else if (req.ch == CH_SLASH) begin
                  state_in = S_LINE_CMT;
               end else begin
                  state_in = text_state;
                  if (text_open) open_line_in = cur_line_ff;
               end
            end
            S_CMT: begin
               if (req.ch == CH_STAR) state_in = S_MAYBE_CLOSE;
               else if (req.ch == CH_SLASH) state_in = S_MAYBE_NEST;
            end
            S_MAYBE_CLOSE: begin
               if (req.ch == CH_SLASH) state_in = S_TEXT;
               else if (req.ch != CH_STAR) state_in = S_CMT;
            end
            S_MAYBE_NEST: begin
               if (req.ch == CH_STAR) begin
                  // outer start line, then the nested start
                  push.count = 2'd2;
                  push.item0 = '{ERR_CMT_START, open_field, 1'b0};
                  push.item1 = '{ERR_NESTED, cur_field, 1'b1};
                  state_in   = S_CMT;
               end else if (req.ch != CH_SLASH) begin
                  state_in = S_CMT;
               end
            end
            S_LINE_CMT: begin
               if (is_nl) state_in = S_TEXT;
            end
            default: begin
               state_in = text_state;
               if (text_open) open_line_in = cur_line_ff;
            end
         endcase
         // saturating line count
         if (is_nl && (cur_line_ff != {LINE_BITS{1'b1}}))
            cur_line_in = cur_line_ff + LINE_BITS'(1);
      end
      if (!accept) push.count = 2'd0;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_TEXT;
         open_line_ff <= '0;
         cur_line_ff  <= LINE_BITS'(1);
      end else if (accept) begin
         state_ff     <= state_in;
         open_line_ff <= open_line_in;
         cur_line_ff  <= cur_line_in;
      end
   end

endmodule

@@ sv/ccsc_out_queue.sv @@
// ----------------------------------------------------------------------------
// ccsc_out_queue: four-entry report queue
// Takes up to two reports per cycle, delivers one per cycle on the rsp side while rsp_stall is low.
// ----------------------------------------------------------------------------
module ccsc_out_queue
   import ccsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ccsc_push_type push,
   output logic          full,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ccsc_rsp_type  rsp_data
);

   ccsc_rsp_type entry_ff [4];
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [2:0]   count_ff, count_in;
   logic         pop;

   // room for two more reports is required before an item is taken
   assign full      = (count_ff > 3'd2);
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // pointer and fill arithmetic
   always_comb begin
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      wr_ptr_in = wr_ptr_ff + push.count;
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // report storage, no reset
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.item0;
      if (push.count == 2'd2) entry_ff[wr_ptr_ff + 2'd1] <= push.item1;
   end

endmodule

@@ sv/c_comment_string_checker.sv @@
// ----------------------------------------------------------------------------
// c_comment_string_checker: C comment and string checker, top level
// Scans source characters and reports unterminated strings and comments.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one source character (ch) or an end-of-file mark per item.
//   rsp channel: error reports (code, line, last_of_run); an item gives
//   zero, one or two reports, the last of them flagged by last_of_run.
//   Reports are registered in the queue before they are shown on rsp.
//   Throughput: one item per cycle while req_stall is low; an item that gives
//   two reports (nested comment start) holds the output for both of them, and
//   the rsp side delivers one report per cycle while rsp_stall is low.
//   A four-entry report queue parts the sides: req_stall rises when fewer
//   than two entries are free, which can follow from rsp_stall held high.
//   Reset: scanner in text state, line 1, queue empty; no clearing pass.
//   End of file returns the scanner to text at line 1.
// ----------------------------------------------------------------------------
module c_comment_string_checker
   import ccsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ccsc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ccsc_rsp_type rsp_data
);

   ccsc_push_type push;
   logic          full;
   logic          accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   // scanner
   ccsc_scanner u_scanner (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push)
   );

   // report queue
   ccsc_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/ccsc_checker.sv @@
// ----------------------------------------------------------------------------
// ccsc_checker: port-level assertions for the checker top level
// Watches the req and rsp channels and the pairing of nested reports.
// ----------------------------------------------------------------------------
module ccsc_checker
   import ccsc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input ccsc_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input ccsc_rsp_type rsp_data
);

   // queue starts empty after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled report holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled report changed");

   // the outer comment start report is never the last of its item
   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.error_code == ERR_CMT_START) |-> !rsp_data.last_of_run)
      else $error("comment start report flagged last");

   // a report that is not last is followed at once by the nested report
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_of_run
      |=> rsp_valid && (rsp_data.error_code == ERR_NESTED))
      else $error("nested report missing after comment start");

endmodule

bind c_comment_string_checker ccsc_checker u_ccsc_checker (.*);

@@ verif/c_comment_string_checker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_string_checker_tb: testbench of the C comment and string checker
// Sends characters and end-of-file marks with random gaps and random report
// stalls. A scanner model inside the scoreboard predicts every error report.
// Reports are compared field by field, in order.
// ----------------------------------------------------------------------------
module c_comment_string_checker_tb;
   import ccsc_pkg::*;

   localparam int RANDOM_ITEMS    = 1750;
   localparam int IDLE_LIMIT      = 4000;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

   // scanner states of the prediction
   typedef enum logic [3:0] {
      SC_TEXT, SC_STR, SC_STR_ESC, SC_CHR, SC_CHR_ESC, SC_MAYBE_STRAY,
      SC_MAYBE_OPEN, SC_CMT, SC_MAYBE_CLOSE, SC_MAYBE_NEST, SC_LINE_CMT
   } scan_state_type;

   // predicts error reports per accepted item and checks reports in order
   class report_scoreboard;
      scan_state_type       state;
      logic [LINE_BITS-1:0] opening_line;
      logic [LINE_BITS-1:0] current_line;
      ccsc_rsp_type         expected_reports[$];
      int                   errors;

      function new();
         state        = SC_TEXT;
         opening_line = '0;
         current_line = LINE_BITS'(1);
         errors       = 0;
      endfunction

      function void add_report(logic [2:0] code, logic [LINE_BITS-1:0] line_no, logic last);
         ccsc_rsp_type rep;
         rep.error_code  = code;
         rep.line        = LINE_FIELD_BITS'(line_no);
         rep.last_of_run = last;
         expected_reports.push_back(rep);
      endfunction

      // plain text: a character may open a string, constant or comment mark
      function void scan_text(logic [7:0] ch);
         case (ch)
            CH_DQUOTE: begin
               opening_line = current_line;
               state        = SC_STR;
            end
            CH_SQUOTE: begin
               opening_line = current_line;
               state        = SC_CHR;
            end
            CH_SLASH: begin
               opening_line = current_line;
               state        = SC_MAYBE_OPEN;
            end
            CH_STAR: state = SC_MAYBE_STRAY;
            default: ;
         endcase
      endfunction

      function void note_item(ccsc_req_type item);
         logic [7:0] ch;
         ch = item.ch;
         if (item.end_of_file) begin
            // open constructs are reported, then back to text at line 1
            case (state)
               SC_STR, SC_STR_ESC: add_report(ERR_STR_EOF, opening_line, 1'b1);
               SC_CHR, SC_CHR_ESC: add_report(ERR_CHR_EOF, opening_line, 1'b1);
               SC_CMT, SC_MAYBE_CLOSE, SC_MAYBE_NEST:
                  add_report(ERR_CMT_EOF, opening_line, 1'b1);
               default: ;
            endcase
            state        = SC_TEXT;
            current_line = LINE_BITS'(1);
            opening_line = '0;
         end else begin
            case (state)
               SC_STR: begin
                  if (ch == CH_NL) begin
                     add_report(ERR_STR_EOL, opening_line, 1'b1);
                     state = SC_TEXT;
                  end else if (ch == CH_DQUOTE) state = SC_TEXT;
                  else if (ch == CH_BSLASH) state = SC_STR_ESC;
               end
               SC_STR_ESC: state = SC_STR;
               SC_CHR: begin
                  if (ch == CH_NL) begin
                     add_report(ERR_CHR_EOL, opening_line, 1'b1);
                     state = SC_TEXT;
                  end else if (ch == CH_SQUOTE) state = SC_TEXT;
                  else if (ch == CH_BSLASH) state = SC_CHR_ESC;
               end
               SC_CHR_ESC: state = SC_CHR;
               SC_MAYBE_STRAY: begin
                  if (ch == CH_SLASH) begin
                     add_report(ERR_STRAY_END, current_line, 1'b1);
                     state = SC_TEXT;
                  end else begin
                     // not an end mark: look at the character again as text
                     state = SC_TEXT;
                     scan_text(ch);
                  end
               end
               SC_MAYBE_OPEN: begin
                  if (ch == CH_STAR) state = SC_CMT;
                  else if (ch == CH_SLASH) state = SC_LINE_CMT;
                  else begin
                     state = SC_TEXT;
                     scan_text(ch);
                  end
               end
               SC_CMT: begin
                  if (ch == CH_STAR) state = SC_MAYBE_CLOSE;
                  else if (ch == CH_SLASH) state = SC_MAYBE_NEST;
               end
               SC_MAYBE_CLOSE: begin
                  if (ch == CH_SLASH) state = SC_TEXT;
                  else if (ch != CH_STAR) state = SC_CMT;
               end
               SC_MAYBE_NEST: begin
                  if (ch == CH_STAR) begin
                     // nested start: outer start line first, then this line
                     add_report(ERR_CMT_START, opening_line, 1'b0);
                     add_report(ERR_NESTED, current_line, 1'b1);
                     state = SC_CMT;
                  end else if (ch != CH_SLASH) state = SC_CMT;
               end
               SC_LINE_CMT: begin
                  if (ch == CH_NL) state = SC_TEXT;
               end
               default: scan_text(ch);
            endcase
            // line counter saturates
            if (ch == CH_NL && current_line != LINE_MAX)
               current_line = current_line + LINE_BITS'(1);
         end
      endfunction

      function void check_report(ccsc_rsp_type got);
         ccsc_rsp_type want;
         if (expected_reports.size() == 0) begin
            $display("%0t: report with none expected: expected none, %s %0d line %0d last %0d",
                     $time, "actual code", got.error_code, got.line, got.last_of_run);
            errors++;
         end else begin
            want = expected_reports.pop_front();
            if (got.error_code !== want.error_code) begin
               $display("%0t: error_code mismatch: expected %0d, actual %0d",
                        $time, want.error_code, got.error_code);
               errors++;
            end
            if (got.line !== want.line) begin
               $display("%0t: line mismatch: expected %0d, actual %0d",
                        $time, want.line, got.line);
               errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
               $display("%0t: last_of_run mismatch: expected %0d, actual %0d",
                        $time, want.last_of_run, got.last_of_run);
               errors++;
            end
         end
      endfunction

      function int pending_count();
         return expected_reports.size();
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   ccsc_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   ccsc_rsp_type rsp_data;

   report_scoreboard scoreboard;
   int  items_sent  = 0;
   int  hold_cycles = 0;
   int  stall_left  = 0;
   bit  req_quiet   = 1'b0;
   bit  rsp_quiet   = 1'b0;

   c_comment_string_checker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // idle length: mostly none, sometimes short, rarely long
   function automatic int pause_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      else if (r < 95) return $urandom_range(1, 3);
      else return $urandom_range(10, 40);
   endfunction

   // body character weighted toward the scanner's special characters
   function automatic logic [7:0] body_char();
      case ($urandom_range(0, 15))
         0: return CH_STAR;
         1: return CH_SLASH;
         2: return CH_BSLASH;
         3: return CH_NL;
         4: return CH_DQUOTE;
         5: return CH_SQUOTE;
         6, 7: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   function automatic logic [7:0] letter();
      return 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input logic [7:0] ch, input logic eof);
      int gap;
      gap = req_quiet ? 0 : pause_length();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.ch          = ch;
      req_data.end_of_file = eof;
      req_valid            = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scoreboard.note_item(req_data);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (scoreboard.pending_count() != 0) @(negedge clock);
   endtask

   // one random piece of source text, mostly well formed
   task automatic send_fragment();
      int kind;
      int len;
      kind = $urandom_range(0, 19);
      len  = $urandom_range(0, 6);
      case (kind)
         0, 1, 2: begin
            repeat (len + 1) send_item(letter(), 1'b0);
            if ($urandom_range(0, 2) == 0) send_item(CH_NL, 1'b0);
         end
         3, 4, 5: begin
            // string, closed or broken by a newline
            send_item(CH_DQUOTE, 1'b0);
            repeat (len) send_item(body_char(), 1'b0);
            send_item(($urandom_range(0, 4) != 0) ? CH_DQUOTE : CH_NL, 1'b0);
         end
         6, 7: begin
            send_item(CH_SQUOTE, 1'b0);
            if ($urandom_range(0, 2) == 0) send_item(CH_BSLASH, 1'b0);
            send_item(body_char(), 1'b0);
            send_item(($urandom_range(0, 4) != 0) ? CH_SQUOTE : CH_NL, 1'b0);
         end
         8, 9, 10: begin
            // block comment, sometimes left open or with a nested start
            send_item(CH_SLASH, 1'b0);
            send_item(CH_STAR, 1'b0);
            repeat (len) send_item(body_char(), 1'b0);
            if ($urandom_range(0, 3) == 0) begin
               send_item(CH_SLASH, 1'b0);
               send_item(CH_STAR, 1'b0);
            end
            if ($urandom_range(0, 5) != 0) begin
               send_item(CH_STAR, 1'b0);
               send_item(CH_SLASH, 1'b0);
            end
         end
         11, 12: begin
            send_item(CH_SLASH, 1'b0);
            send_item(CH_SLASH, 1'b0);
            repeat (len) send_item(body_char(), 1'b0);
            send_item(CH_NL, 1'b0);
         end
         13: begin
            send_item(CH_STAR, 1'b0);
            send_item(CH_SLASH, 1'b0);
         end
         14: begin
            // lone mark followed by something that is re-examined as text
            send_item(($urandom_range(0, 1) != 0) ? CH_STAR : CH_SLASH, 1'b0);
            send_item(body_char(), 1'b0);
         end
         15: send_item(CH_NL, 1'b0);
         16, 17: repeat (len + 1) send_item(8'($urandom_range(0, 255)), 1'b0);
         18: repeat (len + 1) send_item(body_char(), 1'b0);
         default: send_item(8'($urandom_range(0, 255)), 1'b1);
      endcase
   endtask

   // report side: check accepted reports, then pick the next stall
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) scoreboard.check_report(rsp_data);
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
            if (!rsp_quiet) stall_left = pause_length();
         end
      end
   end

   // watchdog: too long without any item moving on either side
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int random_end;
      scoreboard = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // string broken by a newline, top byte inside
      send_item(CH_DQUOTE, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(CH_NL, 1'b0);
      // escaped newline in a string still counts a line; then end of file
      send_item(CH_DQUOTE, 1'b0);
      send_item(CH_BSLASH, 1'b0);
      send_item(CH_NL, 1'b0);
      send_item(8'h5A, 1'b1);
      // escaped quote in a constant, constant broken by a newline
      send_item(CH_SQUOTE, 1'b0);
      send_item(CH_BSLASH, 1'b0);
      send_item(CH_SQUOTE, 1'b0);
      send_item(CH_NL, 1'b0);
      // open constant at end of file, zero byte ignored
      send_item(CH_SQUOTE, 1'b0);
      send_item(8'h00, 1'b1);
      // stray end of comment
      send_item(CH_STAR, 1'b0);
      send_item(CH_SLASH, 1'b0);
      // lone star then a quote: quote opens a string in text
      send_item(CH_STAR, 1'b0);
      send_item(CH_DQUOTE, 1'b0);
      send_item(CH_DQUOTE, 1'b0);
      // line comment
      send_item(CH_SLASH, 1'b0);
      send_item(CH_SLASH, 1'b0);
      send_item(CH_STAR, 1'b0);
      send_item(CH_NL, 1'b0);
      // nested comment start, then comment open at end of file
      send_item(CH_SLASH, 1'b0);
      send_item(CH_STAR, 1'b0);
      send_item(CH_SLASH, 1'b0);
      send_item(CH_STAR, 1'b0);
      send_item(8'hA5, 1'b1);

      // long report hold-off while nested starts keep arriving
      wait_drained();
      req_quiet   = 1'b1;
      hold_cycles = RSP_HOLD_CYCLES;
      send_item(CH_SLASH, 1'b0);
      send_item(CH_STAR, 1'b0);
      repeat (12) begin
         send_item(CH_SLASH, 1'b0);
         send_item(CH_STAR, 1'b0);
      end
      send_item(8'h00, 1'b1);
      req_quiet = 1'b0;
      // sender pauses until every report is in
      wait_drained();

      // random source text, with stretches of no idling on either side
      random_end = items_sent + RANDOM_ITEMS;
      while (items_sent < random_end) begin
         if ($urandom_range(0, 30) == 0) req_quiet = ~req_quiet;
         if ($urandom_range(0, 30) == 0) rsp_quiet = ~rsp_quiet;
         send_fragment();
      end
      send_item(8'h00, 1'b1);

      // short tail back to back: broken string, nested start, open string at eof
      wait_drained();
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      send_item(CH_DQUOTE, 1'b0);
      send_item(CH_NL, 1'b0);
      send_item(CH_SLASH, 1'b0);
      send_item(CH_STAR, 1'b0);
      send_item(CH_SLASH, 1'b0);
      send_item(CH_STAR, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(CH_DQUOTE, 1'b0);
      send_item(8'h7E, 1'b1);

      wait_drained();
      repeat (16) @(negedge clock);
      if (scoreboard.errors == 0 && scoreboard.pending_count() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
sv/ccsc_pkg.sv
sv/ccsc_scanner.sv
sv/ccsc_out_queue.sv
sv/c_comment_string_checker.sv
sv/ccsc_checker.sv
verif/c_comment_string_checker_tb.sv
